// ===== hw/rtl/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 hasher.
package sha_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [0:7] state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic  push;
    logic  step;
    word_t push_word;
  } sched_ctrl_t;

  typedef struct packed {
    logic   load;
    logic   step;
    state_t load_value;
  } round_ctrl_t;

  localparam logic [1:0] ActAbsorb       = 2'd0;
  localparam logic [1:0] ActAbsorbFinish = 2'd1;

  localparam logic [7:0] PadMark = 8'h80;

  localparam state_t HashInit = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;
      6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;
      6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;
      6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;
      6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;
      6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;
      6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;
      6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;
      6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;
      6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;
      6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;
      6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;
      6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;
      6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;
      6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;
      6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;
      6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;
      6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;
      6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;
      6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;
      6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;
      6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;
      6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;
      6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;
      6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;
      6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;
      6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;
      6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;
      6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;
      6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

// ===== hw/rtl/sha_sched.sv =====
// Message schedule as a sixteen-word sliding window, loaded word by word and expanded per round.
module sha_sched (
  input  logic                clk_i,
  input  sha_pkg::sched_ctrl_t ctrl_i,
  output sha_pkg::word_t      w_o
);
  import sha_pkg::*;

  word_t win_q [16];
  word_t win_d [16];
  word_t expand;

  assign expand = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      win_d[i] = win_q[i];
    end
    if (ctrl_i.push || ctrl_i.step) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i + 1];
      end
      win_d[15] = ctrl_i.push ? ctrl_i.push_word : expand;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 16; i++) begin
      win_q[i] <= win_d[i];
    end
  end

  assign w_o = win_q[0];

endmodule

// ===== hw/rtl/sha_round.sv =====
// Working variables a to h and the shared compression round, applied once per cycle while step is set.
module sha_round (
  input  logic                clk_i,
  input  sha_pkg::round_ctrl_t ctrl_i,
  input  sha_pkg::word_t      k_i,
  input  sha_pkg::word_t      w_i,
  output sha_pkg::state_t     v_o
);
  import sha_pkg::*;

  state_t v_q;
  state_t v_d;
  word_t  t1;
  word_t  t2;
  word_t  choose;
  word_t  major;

  assign choose = v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]));
  assign major  = (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);
  assign t1     = v_q[7] + big_sigma1(v_q[4]) + choose + k_i + w_i;
  assign t2     = big_sigma0(v_q[0]) + major;

  always_comb begin
    v_d = v_q;
    if (ctrl_i.load) begin
      v_d = ctrl_i.load_value;
    end else if (ctrl_i.step) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign v_o = v_q;

endmodule

// ===== hw/rtl/sha256_message_hasher_unit.sv =====
// Top level of the SHA-256 hasher: byte intake, padding sequencer, hash state and digest output.
// Each absorbed byte is shifted into the current block; the 64th byte of a block starts the
// compression rounds, followed by an update of the hash state.
// A finish feeds the padding and length bytes at one per cycle through the same path, pausing while
// a block compresses, runs one or two compressions, then presents eight digest beats, one per cycle while taken.
// Reset is asynchronous and active low; it loads the initial hash and clears counts and length.
module sha256_message_hasher_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte_i,
  input  logic [1:0]          action_i,
  output logic                out_valid,
  input  logic                out_ready,
  output sha_pkg::word_t      digest_word_o,
  output logic [2:0]          word_index_o,
  output logic                last_word_o
);
  import sha_pkg::*;

  state_e      state_q, state_d;
  state_e      ret_q, ret_d;
  state_e      after;
  state_t      hash_q, hash_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [2:0]  idx_q, idx_d;
  logic [23:0] word_q, word_d;
  logic        byte_valid;
  logic [7:0]  byte_val;
  logic        full;
  sched_ctrl_t sched_ctrl;
  round_ctrl_t round_ctrl;
  word_t       w;
  state_t      v;

  sha_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (w)
  );

  sha_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (round_ctrl),
    .k_i    (round_k(cnt_q)),
    .w_i    (w),
    .v_o    (v)
  );

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    hash_d     = hash_q;
    bitlen_d   = bitlen_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    after      = state_q;
    byte_valid = 1'b0;
    byte_val   = data_byte_i;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    round_ctrl = '{load: 1'b0, step: 1'b0, load_value: hash_q};
    sched_ctrl = '{push: 1'b0, step: 1'b0, push_word: {word_q, byte_val}};

    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action_i == ActAbsorb || action_i == ActAbsorbFinish) begin
            byte_valid = 1'b1;
            bitlen_d   = bitlen_q + 64'd8;
          end
          after = (action_i == ActAbsorb) ? ST_IDLE : ST_PAD_MARK;
        end
      end
      ST_PAD_MARK: begin
        byte_valid = 1'b1;
        byte_val   = PadMark;
        after      = (fill_q == 6'd55) ? ST_PAD_LEN : ST_PAD_ZERO;
      end
      ST_PAD_ZERO: begin
        byte_valid = 1'b1;
        byte_val   = 8'h00;
        after      = (fill_q == 6'd55) ? ST_PAD_LEN : ST_PAD_ZERO;
      end
      ST_PAD_LEN: begin
        byte_valid = 1'b1;
        byte_val   = bitlen_q[63:56];
        bitlen_d   = {bitlen_q[55:0], 8'h00};
        after      = (fill_q == 6'd63) ? ST_OUT : ST_PAD_LEN;
      end
      ST_ROUND: begin
        round_ctrl.step = 1'b1;
        sched_ctrl.step = 1'b1;
        cnt_d           = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + v[i];
        end
        state_d = ret_q;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            hash_d  = HashInit;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    full = byte_valid && (fill_q == 6'd63);
    sched_ctrl.push_word = {word_q, byte_val};
    sched_ctrl.push      = byte_valid && (fill_q[1:0] == 2'd3);
    round_ctrl.load      = full;

    if (state_q == ST_PAD_MARK || state_q == ST_PAD_ZERO || state_q == ST_PAD_LEN
        || (state_q == ST_IDLE && in_valid)) begin
      if (full) begin
        state_d = ST_ROUND;
        ret_d   = after;
        cnt_d   = 6'd0;
      end else begin
        state_d = after;
      end
    end
  end

  assign fill_d = byte_valid ? fill_q + 6'd1 : fill_q;
  assign word_d = byte_valid ? {word_q[15:0], byte_val} : word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_IDLE;
      hash_q   <= HashInit;
      fill_q   <= 6'd0;
      bitlen_q <= 64'd0;
      cnt_q    <= 6'd0;
      idx_q    <= 3'd0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      hash_q   <= hash_d;
      fill_q   <= fill_d;
      bitlen_q <= bitlen_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign digest_word_o = hash_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

endmodule

// ===== tb/tb_sha256_message_hasher_unit.sv =====
// Self-checking testbench for the SHA-256 message hasher with directed and random messages.
module tb_sha256_message_hasher_unit;
  import sha_pkg::*;

  localparam logic [1:0] ActFinish = 2'd2;
  localparam logic [1:0] ActSpare  = 2'd3;

  localparam logic [7:0] PadByte      = 8'h80;
  localparam int         RandomItems  = 280;
  localparam int         HoldCycles   = 400;
  localparam int         DrainCycles  = 400;
  localparam int         WatchdogMax  = 3000;
  localparam int         ShownErrors  = 10;

  localparam logic [255:0] EmptyDigest =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] AbcDigest =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  localparam word_t IvWords[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundConsts[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_beat_t;

  typedef struct packed {
    logic [7:0]   data;
    logic [1:0]   act;
    logic         typed;
    logic [255:0] digest;
  } stim_row_t;

  localparam int DirectedCount = 16;
  localparam stim_row_t DirectedRows[DirectedCount] = '{
    '{8'h00, ActFinish,       1'b1, EmptyDigest},
    '{8'ha5, ActSpare,        1'b1, EmptyDigest},
    '{8'h61, ActAbsorb,       1'b0, 256'd0},
    '{8'h62, ActAbsorb,       1'b0, 256'd0},
    '{8'h63, ActAbsorbFinish, 1'b1, AbcDigest},
    '{8'h00, ActAbsorbFinish, 1'b0, 256'd0},
    '{8'hff, ActAbsorbFinish, 1'b0, 256'd0},
    '{8'h00, ActAbsorb,       1'b0, 256'd0},
    '{8'hff, ActAbsorb,       1'b0, 256'd0},
    '{8'h55, ActAbsorb,       1'b0, 256'd0},
    '{8'haa, ActAbsorb,       1'b0, 256'd0},
    '{8'h01, ActAbsorb,       1'b0, 256'd0},
    '{8'h80, ActAbsorb,       1'b0, 256'd0},
    '{8'h7f, ActAbsorb,       1'b0, 256'd0},
    '{8'hfe, ActAbsorb,       1'b0, 256'd0},
    '{8'h5a, ActFinish,       1'b0, 256'd0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte_i;
  logic [1:0] action_i;
  logic       out_valid;
  logic       out_ready;
  word_t      digest_word_o;
  logic [2:0] word_index_o;
  logic       last_word_o;

  sha256_message_hasher_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte_i   (data_byte_i),
    .action_i      (action_i),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

  word_t        chain_words[8];
  logic [7:0]   msg_block[64];
  int unsigned  block_fill;
  logic [63:0]  msg_bits;
  digest_beat_t expected_beats[$];

  int mismatch_count = 0;
  int beats_checked  = 0;
  int messages_done  = 0;
  int bytes_absorbed = 0;
  int items_sent     = 0;
  int burst_left     = 1;
  int idle_cycles    = 0;
  bit hold_done      = 1'b0;

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    data_byte_i = 8'h00;
    action_i    = ActAbsorb;
    out_ready   = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    word_t w[64];
    word_t v[8];
    word_t t1;
    word_t t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
             (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    end
    for (int i = 0; i < 8; i++) begin
      v[i] = chain_words[i];
    end
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           (v[6] ^ (v[4] & (v[5] ^ v[6]))) + RoundConsts[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) begin
      chain_words[i] = chain_words[i] + v[i];
    end
  endfunction

  function automatic void clear_hash();
    for (int i = 0; i < 8; i++) begin
      chain_words[i] = IvWords[i];
    end
    block_fill = 0;
    msg_bits   = 64'd0;
  endfunction

  // Updates the hash state for one accepted beat and queues the digest beats a finish causes.
  function automatic void hash_item(input logic [7:0] data, input logic [1:0] act,
                                    input logic typed, input logic [255:0] typed_digest);
    int unsigned  pos;
    digest_beat_t beat;
    if (act == ActAbsorb || act == ActAbsorbFinish) begin
      msg_block[block_fill] = data;
      block_fill = (block_fill + 1) % 64;
      msg_bits = msg_bits + 64'd8;
      bytes_absorbed++;
      if (block_fill == 0) begin
        compress_block();
      end
    end
    if (act == ActAbsorb) begin
      return;
    end
    pos = block_fill;
    msg_block[pos] = PadByte;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      msg_block[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) begin
      msg_block[56+i] = msg_bits[63-8*i -: 8];
    end
    compress_block();
    for (int i = 0; i < 8; i++) begin
      beat.word  = typed ? typed_digest[255-32*i -: 32] : chain_words[i];
      beat.index = 3'(i);
      beat.last  = (i == 7);
      expected_beats = {expected_beats, beat};
    end
    messages_done++;
    clear_hash();
  endfunction

  // Offers one beat, waits for it to be taken, then applies the burst and gap pacing.
  task automatic send_beat(input logic [7:0] data, input logic [1:0] act,
                           input logic typed, input logic [255:0] typed_digest);
    in_valid    <= 1'b1;
    data_byte_i <= data;
    action_i    <= act;
    @(posedge clk_i);
    while (!in_ready) begin
      @(posedge clk_i);
    end
    hash_item(data, act, typed, typed_digest);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic send_message(input int unsigned len);
    bit finish_on_last;
    finish_on_last = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if (finish_on_last && i == len - 1) begin
        send_beat(8'($urandom), ActAbsorbFinish, 1'b0, 256'd0);
      end else begin
        send_beat(8'($urandom), ActAbsorb, 1'b0, 256'd0);
      end
    end
    if (!finish_on_last) begin
      send_beat(8'($urandom), ($urandom_range(0, 3) == 0) ? ActSpare : ActFinish,
                1'b0, 256'd0);
    end
  endtask

  initial begin : stimulus
    int unsigned boundary_lens[8];
    int unsigned sel;
    int unsigned len;
    boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 128};
    clear_hash();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < DirectedCount; r++) begin
      send_beat(DirectedRows[r].data, DirectedRows[r].act, DirectedRows[r].typed,
                DirectedRows[r].digest);
    end
    // Random part: mostly short messages, mixed with lengths around the padding and block edges and longer lengths.
    while (items_sent < DirectedCount + RandomItems) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        len = $urandom_range(0, 10);
      end else if (sel < 80) begin
        len = boundary_lens[$urandom_range(0, 7)];
      end else begin
        len = $urandom_range(0, 100);
      end
      send_message(len);
    end
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d messages, %0d message bytes and %0d input beats,", messages_done,
             bytes_absorbed, items_sent);
    $display("with %0d digest beats compared and one long output stall.", beats_checked);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // The receiver cycles through stall patterns and holds off once for a long stretch.
  initial begin : receiver
    int unsigned cyc;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (!hold_done && beats_checked >= 64) begin
        out_ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        case ((cyc >> 6) % 4)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= (cyc % 3 != 0);
          end
          2: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ready <= ($urandom_range(0, 7) != 0);
          end
        endcase
      end
    end
  end

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= ShownErrors) begin
      $display("Mismatch at %0t: %s", $realtime, what);
    end
  endfunction

  always @(posedge clk_i) begin : check_digest
    digest_beat_t want;
    if (rst_ni && out_valid && out_ready) begin
      beats_checked++;
      if (expected_beats.size() == 0) begin
        note_mismatch($sformatf("unexpected beat word=%08h index=%0d last=%0b",
                                digest_word_o, word_index_o, last_word_o));
      end else begin
        want = expected_beats.pop_front();
        if (digest_word_o !== want.word || word_index_o !== want.index ||
            last_word_o !== want.last) begin
          note_mismatch($sformatf("expected word=%08h index=%0d last=%0b, got %08h %0d %0b",
                                  want.word, want.index, want.last,
                                  digest_word_o, word_index_o, last_word_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogMax) begin
      $display("Watchdog expired after %0d cycles without a beat", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hw/rtl/sha_pkg.sv
hw/rtl/sha_sched.sv
hw/rtl/sha_round.sv
hw/rtl/sha256_message_hasher_unit.sv
tb/tb_sha256_message_hasher_unit.sv
